@@ hdl/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RCM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define RCM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hdl/rcm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rcm_pkg;

  localparam int MAX_REGION_PIXELS = 4096;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 40;
  localparam int DIV_CNT_W = 6;

  localparam logic [2:0] CFG_IMAGE_WIDTH = 3'd0;
  localparam logic [2:0] CFG_X_ORIGIN    = 3'd1;
  localparam logic [2:0] CFG_Y_ORIGIN    = 3'd2;
  localparam logic [2:0] CFG_FLUX_SCALE  = 3'd3;
  localparam logic [2:0] CFG_PEAK_MODE   = 3'd4;

  localparam logic [12:0] RST_IMAGE_WIDTH = 13'd1024;
  localparam logic [15:0] RST_FLUX_SCALE  = 16'd256;

  typedef struct packed {
    logic [23:0]        pixel_index;
    logic signed [19:0] sample;
    logic               last_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [23:0]        center_y;
    logic [23:0]        center_x;
    logic [23:0]        spread_y;
    logic [23:0]        spread_x;
    logic signed [39:0] flux_total;
    logic signed [27:0] max_flux;
    logic [12:0]        pixel_total;
    logic               zero_flux;
  } result_t;

  typedef struct packed {
    logic [12:0] image_width;
    logic [15:0] x_origin;
    logic [15:0] y_origin;
    logic [15:0] flux_scale;
    logic        peak_mode;
  } cfg_t;

  // one classified pixel between front and back
  typedef struct packed {
    logic [15:0]        gx;
    logic [15:0]        gy;
    logic signed [27:0] flux;
    logic               last;
  } ent_t;

  typedef struct packed {
    logic              full;
    logic              valid;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage
`default_nettype wire

@@ hdl/region_centroid_moments.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Region centroid and second moments: feed the pixels of one region (index,
// signed sample, last mark) and get one result beat after the last pixel.
// The front takes one pixel at a time, stalling its input while its 24-step
// index-by-width divider runs and until the entry is pushed; a four-beat
// queue lets it run ahead while the back accumulates at one beat a cycle
// when it is not finishing a region. After a last pixel the back runs two
// 64-step centroid divides in weighted mode, then per axis a 64-step mean
// divide and a 32-step square root, before the result is shown; pixels of
// the next region queue up meanwhile. Registers: 0 image_width, 1 x_origin,
// 2 y_origin, 3 flux_scale, 4 peak_center_mode; write only while idle.
`include "assert_macros.svh"
module region_centroid_moments (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rcm_pkg::pixel_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rcm_pkg::result_t        out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);
  rcm_pkg::cfg_t cfg_r, cfg_nxt;
  rcm_pkg::ent_t push_data, head;
  rcm_pkg::q_status_t q_status;
  logic push, pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        rcm_pkg::CFG_IMAGE_WIDTH: cfg_nxt.image_width = cfg_wdata[12:0];
        rcm_pkg::CFG_X_ORIGIN:    cfg_nxt.x_origin = cfg_wdata;
        rcm_pkg::CFG_Y_ORIGIN:    cfg_nxt.y_origin = cfg_wdata;
        rcm_pkg::CFG_FLUX_SCALE:  cfg_nxt.flux_scale = cfg_wdata;
        rcm_pkg::CFG_PEAK_MODE:   cfg_nxt.peak_mode = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width <= rcm_pkg::RST_IMAGE_WIDTH;
      cfg_r.x_origin <= '0;
      cfg_r.y_origin <= '0;
      cfg_r.flux_scale <= rcm_pkg::RST_FLUX_SCALE;
      cfg_r.peak_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_status.full)
  );

  rcm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  rcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .q_valid   (q_status.valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `RCM_ASSERT_ALWAYS(a_q_bound, q_status.count <= 3'(rcm_pkg::QDEPTH), "queue count over depth")
  `RCM_ASSERT_ALWAYS(a_pop_nonempty, !pop || q_status.count != '0, "pop from empty queue")
  `RCM_ASSERT_NEXT(a_front_busy, in_valid && !in_stall, in_stall, "front took two pixels at once")
endmodule
`default_nettype wire

@@ hdl/rcm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module rcm_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [rcm_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [rcm_pkg::DIV_DEN_W-1:0]  den,
  output logic                                done,
  output logic [rcm_pkg::DIV_NUM_W-1:0]       quot
);
  logic [rcm_pkg::DIV_NUM_W-1:0] q_r, q_nxt;
  logic [rcm_pkg::DIV_DEN_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [rcm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [rcm_pkg::DIV_DEN_W:0] sh;
  logic ge;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r, q_r[rcm_pkg::DIV_NUM_W-1]};
    ge = (sh >= {1'b0, den_r});
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = '1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? sh[rcm_pkg::DIV_DEN_W-1:0] - den_r : sh[rcm_pkg::DIV_DEN_W-1:0];
      q_nxt = {q_r[rcm_pkg::DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

@@ hdl/rcm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rcm_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rcm_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rcm_pkg::pixel_in_t in_data,
  output logic                    push,
  output rcm_pkg::ent_t           push_data,
  input  wire logic               q_full
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [23:0] num_r, num_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;
  logic signed [36:0] prod_r, prod_nxt;
  logic [12:0] w;
  logic [13:0] sh;
  logic        ge;
  logic signed [27:0] flux_sat;

  assign w = (cfg.image_width == '0) ? 13'd1 : cfg.image_width;
  assign sh = {rem_r, num_r[23]};
  assign ge = (sh >= {1'b0, w});

  always_comb begin
    if (prod_r > 37'sd134217727) flux_sat = 28'sh7FFFFFF;
    else if (prod_r < -37'sd134217728) flux_sat = -28'sh8000000;
    else flux_sat = prod_r[27:0];
  end

  always_comb begin
    state_nxt = state_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    last_nxt = last_r;
    prod_nxt = prod_r;
    push = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          num_nxt = in_data.pixel_index;
          rem_nxt = '0;
          cnt_nxt = 5'd23;
          last_nxt = in_data.last_pixel;
          prod_nxt = in_data.sample * $signed({1'b0, cfg.flux_scale});
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt = ge ? 13'(sh - {1'b0, w}) : sh[12:0];
        num_nxt = {num_r[22:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          push = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // quotient is local y, remainder local x
  assign push_data.gx = 16'({3'b000, rem_r} + cfg.x_origin);
  assign push_data.gy = num_r[15:0] + cfg.y_origin;
  assign push_data.flux = flux_sat;
  assign push_data.last = last_r;
  assign in_stall = (state_r != F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    last_r <= last_nxt;
    prod_r <= prod_nxt;
  end
endmodule
`default_nettype wire

@@ hdl/rcm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rcm_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rcm_pkg::ent_t     push_data,
  input  wire logic              pop,
  output rcm_pkg::ent_t          head,
  output rcm_pkg::q_status_t     status
);
  rcm_pkg::ent_t mem_r [rcm_pkg::QDEPTH];
  logic [rcm_pkg::QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [rcm_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= push_data;
  end

  assign head = mem_r[rp_r];
  assign status.count = cnt_r;
  assign status.valid = (cnt_r != '0);
  assign status.full = (cnt_r == rcm_pkg::QCNT_W'(rcm_pkg::QDEPTH));
endmodule
`default_nettype wire

@@ hdl/rcm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rcm_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rcm_pkg::cfg_t      cfg,
  input  wire rcm_pkg::ent_t      head,
  input  wire logic               q_valid,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rcm_pkg::result_t        out_data
);
  typedef enum logic [9:0] {
    B_ACC   = 10'b0000000001,
    B_FIN   = 10'b0000000010,
    B_CDIV  = 10'b0000000100,
    B_CWAIT = 10'b0000001000,
    B_MUL1  = 10'b0000010000,
    B_MUL2  = 10'b0000100000,
    B_TSUB  = 10'b0001000000,
    B_NWAIT = 10'b0010000000,
    B_SQRT  = 10'b0100000000,
    B_OUT   = 10'b1000000000
  } bstate_t;

  bstate_t state_r, state_nxt;

  // stage one: popped beat and its products
  logic p1v_r, p1v_nxt;
  rcm_pkg::ent_t p1_r;
  logic [31:0] sqx_r, sqy_r;
  logic signed [44:0] wx_r, wy_r;

  logic [12:0] cnt_r, cnt_nxt;
  logic [27:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [43:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [55:0] wsx_r, wsx_nxt, wsy_r, wsy_nxt;
  logic signed [39:0] fl_r, fl_nxt;
  logic signed [27:0] pk_r, pk_nxt;
  logic pkv_r, pkv_nxt;
  logic [15:0] pkx_r, pkx_nxt, pky_r, pky_nxt;

  logic axis_r, axis_nxt;
  logic [23:0] cx_r, cx_nxt, cy_r, cy_nxt, spx_r, spx_nxt, spy_r, spy_nxt;
  logic zf_r, zf_nxt, neg_r, neg_nxt;
  logic [51:0] m1_r, m1_nxt;
  logic [36:0] m2_r, m2_nxt;
  logic [63:0] m3_r, m3_nxt;
  logic [63:0] v_r, v_nxt, rt_r, rt_nxt, bit_r, bit_nxt, rb;

  logic out_valid_r, out_valid_nxt;
  rcm_pkg::result_t res_r, res_nxt;

  logic div_start, div_done;
  logic [rcm_pkg::DIV_NUM_W-1:0] div_num, div_quot;
  logic [rcm_pkg::DIV_DEN_W-1:0] div_den;

  logic [55:0] aws;
  logic [39:0] afl;
  logic [23:0] cen_sel, cen_q;
  logic [27:0] s1_sel;
  logic [43:0] s2_sel;
  logic [63:0] t_val;
  logic clr;

  rcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign pop = q_valid && (state_r == B_ACC) && !(p1v_r && p1_r.last);
  assign p1v_nxt = pop;

  always_ff @(posedge clk) begin
    if (pop) begin
      p1_r <= head;
      sqx_r <= head.gx * head.gx;
      sqy_r <= head.gy * head.gy;
      wx_r <= $signed({1'b0, head.gx}) * head.flux;
      wy_r <= $signed({1'b0, head.gy}) * head.flux;
    end
  end

  assign aws = axis_r ? (wsy_r[55] ? 56'(-wsy_r) : wsy_r) : (wsx_r[55] ? 56'(-wsx_r) : wsx_r);
  assign afl = fl_r[39] ? 40'(-fl_r) : fl_r;
  assign cen_sel = axis_r ? cy_r : cx_r;
  assign s1_sel = axis_r ? sy_r : sx_r;
  assign s2_sel = axis_r ? qy_r : qx_r;
  assign t_val = 64'({s2_sel, 16'h0000}) - 64'({m1_r, 9'h000}) + m3_r;
  assign rb = rt_r + bit_r;

  always_comb begin
    if (neg_r && div_quot != '0) cen_q = '0;
    else if (div_quot > 64'hFFFFFF) cen_q = 24'hFFFFFF;
    else cen_q = div_quot[23:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    sx_nxt = sx_r; sy_nxt = sy_r;
    qx_nxt = qx_r; qy_nxt = qy_r;
    wsx_nxt = wsx_r; wsy_nxt = wsy_r;
    fl_nxt = fl_r;
    pk_nxt = pk_r; pkv_nxt = pkv_r; pkx_nxt = pkx_r; pky_nxt = pky_r;
    axis_nxt = axis_r;
    cx_nxt = cx_r; cy_nxt = cy_r; spx_nxt = spx_r; spy_nxt = spy_r;
    zf_nxt = zf_r; neg_nxt = neg_r;
    m1_nxt = m1_r; m2_nxt = m2_r; m3_nxt = m3_r;
    v_nxt = v_r; rt_nxt = rt_r; bit_nxt = bit_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start = 1'b0;
    div_num = {aws, 8'h00} + {25'd0, afl[39:1]};
    div_den = afl;
    clr = 1'b0;
    case (state_r)
      B_ACC: begin
        if (p1v_r) begin
          if (cnt_r < 13'(rcm_pkg::MAX_REGION_PIXELS)) begin
            cnt_nxt = cnt_r + 1'b1;
            sx_nxt = sx_r + 28'(p1_r.gx);
            sy_nxt = sy_r + 28'(p1_r.gy);
            qx_nxt = qx_r + 44'(sqx_r);
            qy_nxt = qy_r + 44'(sqy_r);
            wsx_nxt = wsx_r + 56'(wx_r);
            wsy_nxt = wsy_r + 56'(wy_r);
            fl_nxt = fl_r + 40'(p1_r.flux);
            if (!pkv_r || p1_r.flux > pk_r) begin
              pk_nxt = p1_r.flux;
              pkv_nxt = 1'b1;
              pkx_nxt = p1_r.gx;
              pky_nxt = p1_r.gy;
            end
          end
          if (p1_r.last) state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        axis_nxt = 1'b0;
        zf_nxt = 1'b0;
        if (cnt_r == '0) begin
          cx_nxt = '0; cy_nxt = '0; spx_nxt = '0; spy_nxt = '0;
          state_nxt = B_OUT;
        end else if (cfg.peak_mode) begin
          cx_nxt = {pkx_r, 8'h00};
          cy_nxt = {pky_r, 8'h00};
          state_nxt = B_MUL1;
        end else if (fl_r == '0) begin
          cx_nxt = '0; cy_nxt = '0;
          zf_nxt = 1'b1;
          state_nxt = B_MUL1;
        end else begin
          state_nxt = B_CDIV;
        end
      end
      B_CDIV: begin
        div_start = 1'b1;
        neg_nxt = (axis_r ? wsy_r[55] : wsx_r[55]) ^ fl_r[39];
        state_nxt = B_CWAIT;
      end
      B_CWAIT: begin
        if (div_done) begin
          if (axis_r) begin
            cy_nxt = cen_q;
            axis_nxt = 1'b0;
            state_nxt = B_MUL1;
          end else begin
            cx_nxt = cen_q;
            axis_nxt = 1'b1;
            state_nxt = B_CDIV;
          end
        end
      end
      B_MUL1: begin
        m1_nxt = cen_sel * s1_sel;
        m2_nxt = cnt_r * cen_sel;
        state_nxt = B_MUL2;
      end
      B_MUL2: begin
        m3_nxt = 64'(m2_r) * 64'(cen_sel);
        state_nxt = B_TSUB;
      end
      B_TSUB: begin
        // exact sum of squared offsets, then mean by n
        div_start = 1'b1;
        div_num = t_val;
        div_den = 40'(cnt_r);
        state_nxt = B_NWAIT;
      end
      B_NWAIT: begin
        if (div_done) begin
          v_nxt = div_quot;
          rt_nxt = '0;
          bit_nxt = 64'h4000000000000000;
          state_nxt = B_SQRT;
        end
      end
      B_SQRT: begin
        if (v_r >= rb) begin
          v_nxt = v_r - rb;
          rt_nxt = (rt_r >> 1) + bit_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == 64'd1) begin
          if (axis_r) begin
            spy_nxt = rt_nxt[23:0];
            state_nxt = B_OUT;
          end else begin
            spx_nxt = rt_nxt[23:0];
            axis_nxt = 1'b1;
            state_nxt = B_MUL1;
          end
        end
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          res_nxt.center_y = cy_r;
          res_nxt.center_x = cx_r;
          res_nxt.spread_y = spy_r;
          res_nxt.spread_x = spx_r;
          res_nxt.flux_total = fl_r;
          res_nxt.max_flux = pk_r;
          res_nxt.pixel_total = cnt_r;
          res_nxt.zero_flux = zf_r;
          out_valid_nxt = 1'b1;
          clr = 1'b1;
          state_nxt = B_ACC;
        end
      end
      default: state_nxt = B_ACC;
    endcase
    if (clr) begin
      cnt_nxt = '0;
      sx_nxt = '0; sy_nxt = '0;
      qx_nxt = '0; qy_nxt = '0;
      wsx_nxt = '0; wsy_nxt = '0;
      fl_nxt = '0;
      pk_nxt = '0; pkv_nxt = 1'b0; pkx_nxt = '0; pky_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_ACC;
      p1v_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      sx_r <= '0; sy_r <= '0;
      qx_r <= '0; qy_r <= '0;
      wsx_r <= '0; wsy_r <= '0;
      fl_r <= '0;
      pk_r <= '0; pkv_r <= 1'b0; pkx_r <= '0; pky_r <= '0;
    end else begin
      state_r <= state_nxt;
      p1v_r <= p1v_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
      sx_r <= sx_nxt; sy_r <= sy_nxt;
      qx_r <= qx_nxt; qy_r <= qy_nxt;
      wsx_r <= wsx_nxt; wsy_r <= wsy_nxt;
      fl_r <= fl_nxt;
      pk_r <= pk_nxt; pkv_r <= pkv_nxt; pkx_r <= pkx_nxt; pky_r <= pky_nxt;
    end
    axis_r <= axis_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; spx_r <= spx_nxt; spy_r <= spy_nxt;
    zf_r <= zf_nxt; neg_r <= neg_nxt;
    m1_r <= m1_nxt; m2_r <= m2_nxt; m3_r <= m3_nxt;
    v_r <= v_nxt; rt_r <= rt_nxt; bit_r <= bit_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = res_r;
endmodule
`default_nettype wire
